// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, skip while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property that holds in every cycle, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

    localparam int NODE_BITS         = 10;
    localparam int NODE_COUNT        = 1 << NODE_BITS;
    localparam int PRIO_BITS         = 16;
    localparam int OCC_BITS          = 11;
    localparam int DEF_MAX_ENTRIES   = 1024;
    localparam int DEF_KEY_BITS      = 16;
    localparam int S_TDATA_BITS      = 32;
    localparam int M_TDATA_BITS      = 40;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_POP    = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_QUEUED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_POP_TOP,
        S_POP_LAST,
        S_REM_LAST,
        S_FIND_RD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_PLACE,
        S_DONE
    } state_t;

endpackage

// File: hw/rtl/imhq_ram.sv
// ----------------------------------------------------------------------------
// imhq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module imhq_ram
    import imhq_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ENTRIES,
    parameter int WIDTH = 8
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/imhq_key_cmp.sv
// ----------------------------------------------------------------------------
// imhq_key_cmp
// Shared key comparator used by every sift step.
// ----------------------------------------------------------------------------
module imhq_key_cmp
    import imhq_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS
)
(
    input  logic [KEY_BITS-1:0] key_a,
    input  logic [KEY_BITS-1:0] key_b,
    output logic                a_lt_b
);

    assign a_lt_b = (key_a < key_b);

endmodule

// File: hw/rtl/indexed_min_heap_queue.sv
// One item is in flight at a time.
// Each sift level costs one heap memory read and one pass through the shared
// key comparator (two reads and up to two compares on the way down), which sets the item rate.
// Reset: asynchronous, active low; afterwards a clearing pass marks every
// position map entry absent, with s_tready held low meanwhile.
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of node identifiers keyed by priority with a
// per-node position map; supports add, pop minimum, find and remove.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = DEF_KEY_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // action[1:0], node_id[11:2], priority_req[27:12], zero fill
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // status[1:0], node_out[11:2], priority_out[27:12], is_empty[28],
    // occupancy[39:29]
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready
);

    localparam int IW = $clog2(MAX_ENTRIES);      // heap slot index
    localparam int CW = $clog2(MAX_ENTRIES + 1);  // entry count
    localparam int LW = IW + 2;                   // child index with headroom
    localparam int HW = NODE_BITS + KEY_BITS;     // heap slot {node, key}
    localparam int PW = IW + 1;                   // map entry {valid, slot}

    // ------------------------------------------------------------------
    // Input field extraction
    // ------------------------------------------------------------------
    logic [1:0]              in_action;
    logic [NODE_BITS-1:0]    in_node;
    logic [PRIO_BITS-1:0]    in_prio;
    logic [KEY_BITS+PRIO_BITS-1:0] in_key_wide;

    assign in_action   = s_tdata[1:0];
    assign in_node     = s_tdata[NODE_BITS+1:2];
    assign in_prio     = s_tdata[NODE_BITS+PRIO_BITS+1:NODE_BITS+2];
    // reduce the requested priority to the key width
    assign in_key_wide = {{KEY_BITS{1'b0}}, in_prio};

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [NODE_BITS-1:0]  clr_reg, clr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;

    action_t               act_reg, act_next;
    logic [NODE_BITS-1:0]  node_reg, node_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [NODE_BITS-1:0]  mov_node_reg, mov_node_next;
    logic [KEY_BITS-1:0]   mov_key_reg, mov_key_next;
    logic [NODE_BITS-1:0]  ch_node_reg, ch_node_next;
    logic [KEY_BITS-1:0]   ch_key_reg, ch_key_next;
    logic [IW-1:0]         ch_idx_reg, ch_idx_next;
    status_t               res_status_reg, res_status_next;
    logic [NODE_BITS-1:0]  res_node_reg, res_node_next;
    logic [KEY_BITS-1:0]   res_key_reg, res_key_next;
    logic [M_TDATA_BITS-1:0] out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Memories and the shared comparator
    // ------------------------------------------------------------------
    logic                  heap_we;
    logic [IW-1:0]         heap_waddr, heap_raddr;
    logic [HW-1:0]         heap_wdata, heap_rdata;
    logic                  pos_we;
    logic [NODE_BITS-1:0]  pos_waddr;
    logic [PW-1:0]         pos_wdata, pos_rdata;

    logic [KEY_BITS-1:0]   cmp_a, cmp_b;
    logic                  cmp_lt;

    imhq_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (HW)
    ) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    imhq_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (PW)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (in_node),
        .rdata (pos_rdata)
    );

    imhq_key_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_key_cmp (
        .key_a  (cmp_a),
        .key_b  (cmp_b),
        .a_lt_b (cmp_lt)
    );

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [NODE_BITS-1:0]  rd_node;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  pos_valid;
    logic [IW-1:0]         pos_idx;
    logic                  pos_live;
    logic [LW-1:0]         left_idx, right_idx, count_ext;
    logic [IW-1:0]         parent_idx;
    logic [IW-1:0]         last_idx;
    logic [KEY_BITS+PRIO_BITS-1:0] res_prio_wide;
    logic [CW+OCC_BITS-1:0]        occ_wide;

    assign rd_node    = heap_rdata[HW-1:KEY_BITS];
    assign rd_key     = heap_rdata[KEY_BITS-1:0];
    assign pos_valid  = pos_rdata[IW];
    assign pos_idx    = pos_rdata[IW-1:0];
    assign pos_live   = pos_valid && (CW'(pos_idx) < count_reg);
    assign left_idx   = {1'b0, cur_reg, 1'b1};
    assign right_idx  = left_idx + LW'(1);
    assign count_ext  = LW'(count_reg);
    assign parent_idx = IW'((cur_reg - IW'(1)) >> 1);
    assign last_idx   = IW'(count_reg - CW'(1));

    // ------------------------------------------------------------------
    // Sequencer: next state, memory controls and comparator operands
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        act_next        = act_reg;
        node_next       = node_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        mov_node_next   = mov_node_reg;
        mov_key_next    = mov_key_reg;
        ch_node_next    = ch_node_reg;
        ch_key_next     = ch_key_reg;
        ch_idx_next     = ch_idx_reg;
        res_status_next = res_status_reg;
        res_node_next   = res_node_reg;
        res_key_next    = res_key_reg;
        out_data_next   = out_data_reg;

        heap_we    = 1'b0;
        heap_waddr = cur_reg;
        heap_wdata = {mov_node_reg, mov_key_reg};
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = mov_node_reg;
        pos_wdata  = {1'b1, cur_reg};
        cmp_a      = mov_key_reg;
        cmp_b      = rd_key;
        s_tready   = 1'b0;

        res_prio_wide = {{PRIO_BITS{1'b0}}, res_key_reg};
        occ_wide      = {{OCC_BITS{1'b0}}, count_reg};

        // drop the result once the sink takes it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // mark one map entry absent per cycle
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
                clr_next  = clr_reg + NODE_BITS'(1);
                if (clr_reg == NODE_BITS'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    act_next        = action_t'(in_action);
                    node_next       = in_node;
                    key_next        = in_key_wide[KEY_BITS-1:0];
                    res_status_next = ST_OK;
                    res_node_next   = in_node;
                    res_key_next    = '0;
                    state_next      = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        if (pos_valid)
                        begin
                            res_status_next = ST_QUEUED;
                            state_next      = S_DONE;
                        end
                        else if (count_reg == CW'(MAX_ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cur_next      = IW'(count_reg);
                            mov_node_next = node_reg;
                            mov_key_next  = key_reg;
                            count_next    = count_reg + CW'(1);
                            state_next    = S_UP_RD;
                        end
                    end
                    ACT_POP:
                    begin
                        heap_raddr = '0;
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_ABSENT;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_POP_TOP;
                        end
                    end
                    ACT_FIND:
                    begin
                        heap_raddr = pos_idx;
                        if (pos_live)
                        begin
                            state_next = S_FIND_RD;
                        end
                        else
                        begin
                            res_status_next = ST_ABSENT;
                            state_next      = S_DONE;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        heap_raddr = last_idx;
                        if (pos_live)
                        begin
                            // clear the removed node's map entry now
                            pos_we     = 1'b1;
                            pos_waddr  = node_reg;
                            pos_wdata  = '0;
                            cur_next   = pos_idx;
                            count_next = count_reg - CW'(1);
                            state_next = S_REM_LAST;
                        end
                        else
                        begin
                            res_status_next = ST_ABSENT;
                            state_next      = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_POP_TOP:
            begin
                res_node_next = rd_node;
                res_key_next  = rd_key;
                heap_raddr    = last_idx;
                count_next    = count_reg - CW'(1);
                state_next    = S_POP_LAST;
            end

            S_POP_LAST:
            begin
                pos_we        = 1'b1;
                pos_waddr     = res_node_reg;
                pos_wdata     = '0;
                mov_node_next = rd_node;
                mov_key_next  = rd_key;
                cur_next      = '0;
                state_next    = (count_reg == '0) ? S_DONE : S_DN_RD;
            end

            S_REM_LAST:
            begin
                mov_node_next = rd_node;
                mov_key_next  = rd_key;
                state_next    = (CW'(cur_reg) == count_reg) ? S_DONE : S_UP_RD;
            end

            S_FIND_RD:
            begin
                res_key_next = rd_key;
                state_next   = S_DONE;
            end

            S_UP_RD:
            begin
                heap_raddr = parent_idx;
                if (cur_reg == '0)
                begin
                    state_next = (act_reg == ACT_REMOVE) ? S_DN_RD : S_PLACE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                cmp_a = mov_key_reg;
                cmp_b = rd_key;
                if (cmp_lt)
                begin
                    // move the parent down into the hole
                    heap_we    = 1'b1;
                    heap_waddr = cur_reg;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_node;
                    pos_wdata  = {1'b1, cur_reg};
                    cur_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = (act_reg == ACT_REMOVE) ? S_DN_RD : S_PLACE;
                end
            end

            S_DN_RD:
            begin
                heap_raddr = left_idx[IW-1:0];
                state_next = (left_idx < count_ext) ? S_DN_L : S_PLACE;
            end

            S_DN_L:
            begin
                ch_node_next = rd_node;
                ch_key_next  = rd_key;
                ch_idx_next  = left_idx[IW-1:0];
                heap_raddr   = right_idx[IW-1:0];
                state_next   = (right_idx < count_ext) ? S_DN_R : S_DN_CMP;
            end

            S_DN_R:
            begin
                // take the right child only when it is strictly smaller
                cmp_a = rd_key;
                cmp_b = ch_key_reg;
                if (cmp_lt)
                begin
                    ch_node_next = rd_node;
                    ch_key_next  = rd_key;
                    ch_idx_next  = right_idx[IW-1:0];
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                cmp_a = ch_key_reg;
                cmp_b = mov_key_reg;
                if (cmp_lt)
                begin
                    // move the child up into the hole
                    heap_we    = 1'b1;
                    heap_waddr = cur_reg;
                    heap_wdata = {ch_node_reg, ch_key_reg};
                    pos_we     = 1'b1;
                    pos_waddr  = ch_node_reg;
                    pos_wdata  = {1'b1, cur_reg};
                    cur_next   = ch_idx_reg;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                heap_we    = 1'b1;
                heap_waddr = cur_reg;
                heap_wdata = {mov_node_reg, mov_key_reg};
                pos_we     = 1'b1;
                pos_waddr  = mov_node_reg;
                pos_wdata  = {1'b1, cur_reg};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {occ_wide[OCC_BITS-1:0],
                                      (count_reg == '0),
                                      res_prio_wide[PRIO_BITS-1:0],
                                      res_node_reg,
                                      res_status_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        node_reg       <= node_next;
        key_reg        <= key_next;
        cur_reg        <= cur_next;
        mov_node_reg   <= mov_node_next;
        mov_key_reg    <= mov_key_next;
        ch_node_reg    <= ch_node_next;
        ch_key_reg     <= ch_key_next;
        ch_idx_reg     <= ch_idx_next;
        res_status_reg <= res_status_next;
        res_node_reg   <= res_node_next;
        res_key_reg    <= res_key_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_count_bound, count_reg <= CW'(MAX_ENTRIES), "entry count above capacity")
    `ASSERT_CLK(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "second item taken early")
    `ASSERT_CLK(a_no_heap_wr_clear, (state_reg == S_CLEAR) |-> !heap_we, "heap write during clear")
    `ASSERT_CLK(a_count_step, $past(state_reg) == S_IDLE |-> $stable(count_reg), "count moved in idle")

endmodule

// File: tb/indexed_min_heap_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_test
// Drives add, pop, find and remove requests into the heap queue, keeps a
// software heap with a position map alongside, and compares every response.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_test;
    import imhq_pkg::*;

    localparam int HEAP_SLOTS = DEF_MAX_ENTRIES;
    localparam int RANDOM_ITEMS = 300;

    // Packed from the highest bit down, so status lands in the lowest bits
    // exactly as on m_tdata.
    typedef struct packed {
        logic [OCC_BITS-1:0]  occ;
        logic                 empty;
        logic [PRIO_BITS-1:0] prio;
        logic [NODE_BITS-1:0] node;
        logic [1:0]           status;
    } response_t;

    // One row of the directed table; check_now marks rows whose response is
    // typed in by hand rather than taken from the shadow heap.
    typedef struct {
        action_t              act;
        logic [NODE_BITS-1:0] node;
        logic [PRIO_BITS-1:0] prio;
        bit                   check_now;
        response_t            resp;
    } table_row_t;

    logic                    clk;
    logic                    rst_n;
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tvalid;
    logic                    m_tready;

    indexed_min_heap_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow heap: slot arrays, per-node position map and entry count.
    logic [NODE_BITS-1:0] shadow_node [HEAP_SLOTS];
    logic [PRIO_BITS-1:0] shadow_key [HEAP_SLOTS];
    int                   node_slot [NODE_COUNT];
    bit                   node_queued [NODE_COUNT];
    int                   entry_total;

    response_t pending_responses[$];
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;

    function automatic void swap_slots(int a, int b);
        logic [NODE_BITS-1:0] tn;
        logic [PRIO_BITS-1:0] tk;
        tn = shadow_node[a];
        tk = shadow_key[a];
        shadow_node[a] = shadow_node[b];
        shadow_key[a] = shadow_key[b];
        shadow_node[b] = tn;
        shadow_key[b] = tk;
        node_slot[shadow_node[a]] = a;
        node_slot[shadow_node[b]] = b;
    endfunction

    function automatic int sift_up(int i);
        int p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (shadow_key[i] < shadow_key[p])
            begin
                swap_slots(i, p);
                i = p;
            end
            else
                break;
        end
        return i;
    endfunction

    function automatic void sift_down(int i);
        int l;
        int s;
        forever
        begin
            l = 2 * i + 1;
            if (l >= entry_total)
                break;
            s = l;
            if (l + 1 < entry_total && shadow_key[l] > shadow_key[l + 1])
                s = l + 1;
            if (shadow_key[i] > shadow_key[s])
            begin
                swap_slots(i, s);
                i = s;
            end
            else
                break;
        end
    endfunction

    // Apply one request to the shadow heap and return the response it causes.
    function automatic response_t apply_request(action_t act, logic [NODE_BITS-1:0] nd,
                                                logic [PRIO_BITS-1:0] pr);
        response_t r;
        int        i;
        logic [NODE_BITS-1:0] top;
        r.status = ST_OK;
        r.node = nd;
        r.prio = '0;
        case (act)
            ACT_ADD:
            begin
                if (node_queued[nd])
                    r.status = ST_QUEUED;
                else if (entry_total >= HEAP_SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    i = entry_total;
                    shadow_node[i] = nd;
                    shadow_key[i] = pr;
                    node_slot[nd] = i;
                    node_queued[nd] = 1'b1;
                    entry_total++;
                    void'(sift_up(i));
                end
            end
            ACT_POP:
            begin
                if (entry_total == 0)
                    r.status = ST_ABSENT;
                else
                begin
                    top = shadow_node[0];
                    r.node = top;
                    r.prio = shadow_key[0];
                    entry_total--;
                    if (entry_total > 0)
                    begin
                        swap_slots(0, entry_total);
                        sift_down(0);
                    end
                    node_queued[top] = 1'b0;
                    node_slot[top] = 0;
                end
            end
            ACT_FIND:
            begin
                if (node_queued[nd] && node_slot[nd] < entry_total)
                    r.prio = shadow_key[node_slot[nd]];
                else
                    r.status = ST_ABSENT;
            end
            default:
            begin
                if (!node_queued[nd] || node_slot[nd] >= entry_total)
                    r.status = ST_ABSENT;
                else
                begin
                    i = node_slot[nd];
                    if (i != entry_total - 1)
                        swap_slots(i, entry_total - 1);
                    entry_total--;
                    node_queued[nd] = 1'b0;
                    node_slot[nd] = 0;
                    if (i < entry_total)
                    begin
                        i = sift_up(i);
                        sift_down(i);
                    end
                end
            end
        endcase
        r.empty = (entry_total == 0);
        r.occ = entry_total[OCC_BITS-1:0];
        return r;
    endfunction

    // Hold one request on the slave side until its transaction completes.
    // Wait for a falling edge first so the drop of s_tvalid from the last
    // request and the next raise never share a time step.
    task automatic send_request(action_t act, logic [NODE_BITS-1:0] nd,
                                logic [PRIO_BITS-1:0] pr, bit use_row, response_t row_resp);
        response_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_tdata <= {4'b0, pr, nd, act};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(act, nd, pr);
        if (use_row && predicted !== row_resp)
        begin
            $display("%0t: directed row disagrees with shadow heap: exp %h got %h",
                     $time, row_resp, predicted);
            error_count++;
        end
        pending_responses = {pending_responses, (use_row ? row_resp : predicted)};
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Receiver: stall at random, check each accepted response in order.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        response_t got;
        response_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[39:0];
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, got);
                error_count++;
            end
            else
            begin
                exp_r = pending_responses.pop_front();
                if (got.status !== exp_r.status || got.node !== exp_r.node ||
                    got.prio !== exp_r.prio || got.empty !== exp_r.empty ||
                    got.occ !== exp_r.occ)
                begin
                    $display("%0t: mismatch exp st=%0d node=%0d prio=%0d empty=%0d occ=%0d",
                             $time, exp_r.status, exp_r.node, exp_r.prio, exp_r.empty,
                             exp_r.occ);
                    $display("%0t:          got st=%0d node=%0d prio=%0d empty=%0d occ=%0d",
                             $time, got.status, got.node, got.prio, got.empty, got.occ);
                    error_count++;
                end
            end
        end
    end

    function automatic response_t make_resp(status_t st, int nd, int pr, int occ);
        response_t r;
        r.status = st;
        r.node = NODE_BITS'(nd);
        r.prio = PRIO_BITS'(pr);
        r.empty = (occ == 0);
        r.occ = OCC_BITS'(occ);
        return r;
    endfunction

    function automatic table_row_t row(action_t act, int nd, int pr, bit chk,
                                       response_t resp);
        table_row_t t;
        t.act = act;
        t.node = NODE_BITS'(nd);
        t.prio = PRIO_BITS'(pr);
        t.check_now = chk;
        t.resp = resp;
        return t;
    endfunction

    // Pick a node: one that is queued with probability hit_pct, else any node.
    function automatic logic [NODE_BITS-1:0] pick_node(int hit_pct);
        if (entry_total > 0 && $urandom_range(99) < hit_pct)
            return shadow_node[$urandom_range(entry_total - 1)];
        return NODE_BITS'($urandom_range(NODE_COUNT - 1));
    endfunction

    task automatic random_request(int add_pct, bit wide_keys);
        action_t act;
        int      roll;
        logic [PRIO_BITS-1:0] pr;
        roll = $urandom_range(99);
        if (roll < add_pct)
            act = ACT_ADD;
        else
        begin
            case ($urandom_range(2))
                0: act = ACT_POP;
                1: act = ACT_FIND;
                default: act = ACT_REMOVE;
            endcase
        end
        // Narrow keys produce many ties, which exercise the strict compares.
        pr = wide_keys ? PRIO_BITS'($urandom_range(65535)) : PRIO_BITS'($urandom_range(7));
        send_request(act, pick_node(act == ACT_ADD ? 10 : 80), pr, 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (pending_responses.size() != 0)
            @(negedge clk);
    endtask

    table_row_t directed_rows[$];

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        error_count = 0;
        entry_total = 0;
        send_idle_pct = 16;
        recv_idle_pct = 73;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            node_queued[n] = 1'b0;
            node_slot[n] = 0;
        end

        // Directed table: empty-heap errors, extremes, duplicates, every action.
        directed_rows = '{
            row(ACT_POP, 0, 0, 1, make_resp(ST_ABSENT, 0, 0, 0)),
            row(ACT_FIND, 1023, 0, 1, make_resp(ST_ABSENT, 1023, 0, 0)),
            row(ACT_REMOVE, 512, 0, 1, make_resp(ST_ABSENT, 512, 0, 0)),
            row(ACT_ADD, 1023, 65535, 1, make_resp(ST_OK, 1023, 0, 1)),
            row(ACT_ADD, 1023, 5, 1, make_resp(ST_QUEUED, 1023, 0, 1)),
            row(ACT_FIND, 1023, 0, 1, make_resp(ST_OK, 1023, 65535, 1)),
            row(ACT_ADD, 0, 0, 1, make_resp(ST_OK, 0, 0, 2)),
            row(ACT_ADD, 341, 21845, 0, '0),
            row(ACT_ADD, 682, 43690, 0, '0),
            row(ACT_ADD, 7, 0, 0, '0),
            row(ACT_ADD, 8, 100, 0, '0),
            row(ACT_FIND, 682, 0, 0, '0),
            row(ACT_REMOVE, 341, 0, 0, '0),
            row(ACT_REMOVE, 341, 0, 0, '0),
            row(ACT_POP, 0, 0, 0, '0),
            row(ACT_POP, 0, 0, 0, '0),
            row(ACT_REMOVE, 1023, 0, 0, '0),
            row(ACT_POP, 0, 0, 0, '0),
            row(ACT_POP, 0, 0, 0, '0),
            row(ACT_POP, 99, 0, 1, make_resp(ST_ABSENT, 99, 0, 0))
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].act, directed_rows[k].node, directed_rows[k].prio,
                         directed_rows[k].check_now, directed_rows[k].resp);

        // Hold off until the queue of responses drains once.
        wait_drained();

        // Fill to capacity with every node, then add a node that is already queued.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < NODE_COUNT; n++)
            send_request(ACT_ADD, NODE_BITS'(n), PRIO_BITS'($urandom_range(65535)),
                         1'b0, '0);
        send_request(ACT_ADD, NODE_BITS'(5), PRIO_BITS'(1), 1'b0, '0);
        wait_drained();
        // Full heap: a duplicate add is refused as already queued; then remove one
        // node and add it back, which fills the heap again.
        send_request(ACT_REMOVE, NODE_BITS'(77), '0, 1'b0, '0);
        send_request(ACT_ADD, NODE_BITS'(77), PRIO_BITS'(3), 1'b0, '0);
        for (int n = 0; n < 300; n++)
            send_request(ACT_POP, '0, '0, 1'b0, '0);
        for (int n = 0; n < 124; n++)
            send_request(n[0] ? ACT_REMOVE : ACT_POP, pick_node(90), '0, 1'b0, '0);

        // Random phases with the idling split swapped, then without idling.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 16 : 0;
            for (int k = 0; k < RANDOM_ITEMS / 3; k++)
                random_request(k < 50 ? 60 : 35, 1'($urandom_range(1)));
        end

        wait_drained();
        repeat (200) @(negedge clk);
        if (error_count == 0 && pending_responses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: well above the slowest legal run with both sides stalling.
    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
